>>> src/mode_blink_code_led_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// led sequencer assertion macros
// clocked property checks shared by the sequencer modules
// ----------------------------------------------------------------------------
`ifndef MODE_BLINK_CODE_LED_SEQUENCER_UNIT_MACROS_SVH
`define MODE_BLINK_CODE_LED_SEQUENCER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MBCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MBCL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MBCL_ASSERT(lbl, prop, msg)
`define MBCL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/mbcl_pkg.sv
// ----------------------------------------------------------------------------
// led sequencer package
// item kinds, fixed constants, register defaults and control structs
// ----------------------------------------------------------------------------
package mbcl_pkg;

  localparam int unsigned FLASH_COUNT = 5;
  localparam logic [3:0]  FLASH_STEPS = 4'(2 * FLASH_COUNT);
  localparam logic [1:0]  MODE_TOTAL  = 2'd3;

  localparam logic [15:0] PULSE_ON_RST    = 16'd200;
  localparam logic [15:0] PULSE_GAP_RST   = 16'd200;
  localparam logic [15:0] CYCLE_PAUSE_RST = 16'd1000;
  localparam logic [15:0] FLASH_PHASE_RST = 16'd60;
  localparam logic [15:0] ERROR_PHASE_RST = 16'd1000;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_MODE  = 2'd1,
    KIND_SAVE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_PULSE_ON    = 3'd0,
    REG_PULSE_GAP   = 3'd1,
    REG_CYCLE_PAUSE = 3'd2,
    REG_FLASH_PHASE = 3'd3,
    REG_ERROR_PHASE = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_ON    = 3'b001,
    PH_OFF   = 3'b010,
    PH_PAUSE = 3'b100
  } blink_phase_e;

  typedef struct packed {
    logic       tick;
    logic       set_mode;
    logic [1:0] mode;
    logic       flash_end;
  } blink_ctrl_t;

  typedef struct packed {
    logic tick;
    logic error;
    logic save;
  } ov_ctrl_t;

  typedef struct packed {
    logic error_q;
    logic flash_q;
    logic flash_end;
    logic error_d;
    logic error_phase_d;
    logic flash_d;
    logic flash_odd_d;
  } ov_stat_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == ELAPSED_MAX) ? v : v + 16'd1;
  endfunction

endpackage

>>> src/mbcl_blink.sv
// ----------------------------------------------------------------------------
// blink code engine
// pulse, gap and pause sequencing of the status led and active mode
// ----------------------------------------------------------------------------
`include "mode_blink_code_led_sequencer_unit_macros.svh"

module mbcl_blink (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbcl_pkg::blink_ctrl_t ctrl_i,
  input  logic [15:0]         pulse_on_i,
  input  logic [15:0]         pulse_gap_i,
  input  logic [15:0]         cycle_pause_i,
  output logic                status_d_o,
  output logic [1:0]          mode_d_o
);
  import mbcl_pkg::*;

  blink_phase_e phase_q, phase_d;
  logic [15:0]  elapsed_q, elapsed_d;
  logic [1:0]   done_q, done_d;
  logic [1:0]   wanted_q, wanted_d;
  logic [1:0]   mode_q, mode_d;
  logic         status_q, status_d;
  logic [15:0]  elapsed_inc;
  logic [15:0]  limit;
  logic [1:0]   req_mode;

  assign elapsed_inc = sat_inc(elapsed_q);
  assign req_mode    = (ctrl_i.mode >= MODE_TOTAL) ? 2'd0 : ctrl_i.mode;

  always_comb begin
    case (phase_q)
      PH_ON:    limit = pulse_on_i;
      PH_OFF:   limit = pulse_gap_i;
      default:  limit = cycle_pause_i;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    done_d    = done_q;
    wanted_d  = wanted_q;
    mode_d    = mode_q;
    status_d  = status_q;
    if (ctrl_i.set_mode) begin
      mode_d    = req_mode;
      wanted_d  = req_mode + 2'd1;
      done_d    = 2'd0;
      phase_d   = PH_ON;
      elapsed_d = '0;
      status_d  = 1'b1;
    end else if (ctrl_i.tick) begin
      case (phase_q)
        PH_ON, PH_OFF, PH_PAUSE: begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= limit) begin
            elapsed_d = '0;
            case (phase_q)
              PH_ON: begin
                status_d = 1'b0;
                done_d   = done_q + 2'd1;
                phase_d  = PH_OFF;
              end
              PH_OFF: begin
                if (done_q < wanted_q) begin
                  status_d = 1'b1;
                  phase_d  = PH_ON;
                end else begin
                  phase_d = PH_PAUSE;
                end
              end
              default: begin
                done_d   = 2'd0;
                status_d = 1'b1;
                phase_d  = PH_ON;
              end
            endcase
          end
        end
        default: ;
      endcase
      if (ctrl_i.flash_end) begin
        status_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_ON;
      elapsed_q <= '0;
      done_q    <= 2'd0;
      wanted_q  <= 2'd1;
      mode_q    <= 2'd0;
      status_q  <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      done_q    <= done_d;
      wanted_q  <= wanted_d;
      mode_q    <= mode_d;
      status_q  <= status_d;
    end
  end

  assign status_d_o = status_d;
  assign mode_d_o   = mode_d;

  `MBCL_ASSERT(a_done_le_wanted, done_q <= wanted_q, "pulse count passed the wanted count")
  `MBCL_ASSERT(a_mode_range, mode_q < MODE_TOTAL, "active mode out of range")

endmodule

>>> src/mbcl_overlay.sv
// ----------------------------------------------------------------------------
// flash and error overlay
// save confirmation flashes and latched error alternation
// ----------------------------------------------------------------------------
`include "mode_blink_code_led_sequencer_unit_macros.svh"

module mbcl_overlay (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbcl_pkg::ov_ctrl_t ctrl_i,
  input  logic [15:0]      flash_phase_i,
  input  logic [15:0]      error_phase_i,
  output mbcl_pkg::ov_stat_t stat_o
);
  import mbcl_pkg::*;

  logic        flash_q, flash_d;
  logic [3:0]  step_q, step_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic        error_q, error_d;
  logic        err_ph_q, err_ph_d;
  logic        flash_end;
  logic [15:0] elapsed_inc;
  logic [3:0]  step_inc;

  assign elapsed_inc = sat_inc(elapsed_q);
  assign step_inc    = step_q + 4'd1;

  always_comb begin
    flash_d   = flash_q;
    step_d    = step_q;
    elapsed_d = elapsed_q;
    error_d   = error_q;
    err_ph_d  = err_ph_q;
    flash_end = 1'b0;
    if (error_q) begin
      if (ctrl_i.tick) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= error_phase_i) begin
          elapsed_d = '0;
          err_ph_d  = ~err_ph_q;
        end
      end
    end else if (ctrl_i.error) begin
      error_d   = 1'b1;
      err_ph_d  = 1'b0;
      elapsed_d = '0;
      flash_d   = 1'b0;
      step_d    = '0;
    end else if (ctrl_i.tick) begin
      if (flash_q) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= flash_phase_i) begin
          elapsed_d = '0;
          step_d    = step_inc;
          if (step_inc >= FLASH_STEPS) begin
            step_d    = '0;
            flash_d   = 1'b0;
            flash_end = 1'b1;
          end
        end
      end
    end else if (ctrl_i.save && !flash_q) begin
      flash_d   = 1'b1;
      step_d    = '0;
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_q   <= 1'b0;
      step_q    <= '0;
      elapsed_q <= '0;
      error_q   <= 1'b0;
      err_ph_q  <= 1'b0;
    end else begin
      flash_q   <= flash_d;
      step_q    <= step_d;
      elapsed_q <= elapsed_d;
      error_q   <= error_d;
      err_ph_q  <= err_ph_d;
    end
  end

  assign stat_o = '{
    error_q:       error_q,
    flash_q:       flash_q,
    flash_end:     flash_end,
    error_d:       error_d,
    error_phase_d: err_ph_d,
    flash_d:       flash_d,
    flash_odd_d:   step_d[0]
  };

  `MBCL_ASSERT(a_error_sticky, error_q |=> error_q, "error latch dropped before reset")
  `MBCL_ASSERT(a_step_range, step_q < FLASH_STEPS, "flash step beyond flash count")
  `MBCL_ASSERT(a_no_flash_in_error, error_q |-> !flash_q, "flash running under error")

endmodule

>>> src/mode_blink_code_led_sequencer_unit.sv
// ----------------------------------------------------------------------------
// mode blink code led sequencer
// an accepted item passes the input register, then the result register, before its result is valid
// throughput: one item per cycle while the output is not stalled, set by the single-pass next-state logic
// a result held by an output stall keeps the input register full and stalls the input until it is taken
// reset: asynchronous, config registers to defaults, led code restarts with status on
// ----------------------------------------------------------------------------
`include "mode_blink_code_led_sequencer_unit_macros.svh"

module mode_blink_code_led_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_led_o,
  output logic        mode_one_led_o,
  output logic        mode_two_led_o,
  output logic        mode_three_led_o
);
  import mbcl_pkg::*;

  logic [15:0] pulse_on_q, pulse_gap_q, cycle_pause_q, flash_phase_q, error_phase_q;
  logic        in_valid_q;
  kind_e       kind_q;
  logic [1:0]  mode_q;
  logic        out_valid_q;
  logic [3:0]  leds_q, leds_d;
  logic        out_free;
  logic        adv;
  blink_ctrl_t bctrl;
  ov_ctrl_t    octrl;
  ov_stat_t    ostat;
  logic        status_d;
  logic [1:0]  amode_d;
  logic        s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_on_q    <= PULSE_ON_RST;
      pulse_gap_q   <= PULSE_GAP_RST;
      cycle_pause_q <= CYCLE_PAUSE_RST;
      flash_phase_q <= FLASH_PHASE_RST;
      error_phase_q <= ERROR_PHASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PULSE_ON:    pulse_on_q    <= cfg_data_i;
        REG_PULSE_GAP:   pulse_gap_q   <= cfg_data_i;
        REG_CYCLE_PAUSE: cycle_pause_q <= cfg_data_i;
        REG_FLASH_PHASE: flash_phase_q <= cfg_data_i;
        REG_ERROR_PHASE: error_phase_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q <= kind_e'(kind_i);
      mode_q <= mode_i;
    end
  end

  assign octrl = '{
    tick:  adv && (kind_q == KIND_TICK),
    error: adv && (kind_q == KIND_ERROR),
    save:  adv && (kind_q == KIND_SAVE)
  };

  assign bctrl = '{
    tick:      adv && (kind_q == KIND_TICK) && !ostat.error_q,
    set_mode:  adv && (kind_q == KIND_MODE) && !ostat.error_q && !ostat.flash_q,
    mode:      mode_q,
    flash_end: ostat.flash_end
  };

  mbcl_blink u_blink (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (bctrl),
    .pulse_on_i    (pulse_on_q),
    .pulse_gap_i   (pulse_gap_q),
    .cycle_pause_i (cycle_pause_q),
    .status_d_o    (status_d),
    .mode_d_o      (amode_d)
  );

  mbcl_overlay u_overlay (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (octrl),
    .flash_phase_i (flash_phase_q),
    .error_phase_i (error_phase_q),
    .stat_o        (ostat)
  );

  always_comb begin
    s = 1'b0;
    if (ostat.error_d) begin
      s      = !ostat.error_phase_d;
      leds_d = {s, s, !s, !s};
    end else if (ostat.flash_d) begin
      s      = !ostat.flash_odd_d;
      leds_d = {s, s, s, s};
    end else begin
      leds_d = {status_d, amode_d == 2'd0, amode_d == 2'd1, amode_d == 2'd2};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      leds_q <= leds_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_led_o     = leds_q[3];
  assign mode_one_led_o   = leds_q[2];
  assign mode_two_led_o   = leds_q[1];
  assign mode_three_led_o = leds_q[0];

  `MBCL_ASSERT(a_adv_gives_result, adv |=> out_valid_q, "item advanced without a result")
  `MBCL_ASSERT(a_stall_needs_full, in_stall_o |-> (in_valid_q && out_valid_q), "stall without a full pipe")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led blink code sequencer testbench
// drives ticks, mode changes, save confirms and errors through the valid and
// stall handshake under random bursts and stalls, predicts the four led levels
// of every accepted item and checks each returned item in order
// ----------------------------------------------------------------------------
module tb;
  import mbcl_pkg::*;

  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct packed {
    logic status;
    logic mode_one;
    logic mode_two;
    logic mode_three;
  } led_levels_t;

  class led_scoreboard;
    logic [15:0]  on_ms, gap_ms, pause_ms, flash_ms, err_ms;
    blink_phase_e phase;
    logic [15:0]  blink_cnt, overlay_cnt;
    logic [1:0]   pulses_done, pulses_wanted, active_mode;
    logic [3:0]   flash_step;
    logic         status, flash_on, err_on, err_phase;
    led_levels_t  levels_q[$];
    int unsigned  mismatches;
    int unsigned  results_seen;

    function new();
      on_ms = PULSE_ON_RST;
      gap_ms = PULSE_GAP_RST;
      pause_ms = CYCLE_PAUSE_RST;
      flash_ms = FLASH_PHASE_RST;
      err_ms = ERROR_PHASE_RST;
      phase = PH_ON;
      blink_cnt = '0;
      overlay_cnt = '0;
      pulses_done = '0;
      pulses_wanted = 2'd1;
      active_mode = '0;
      flash_step = '0;
      status = 1'b1;
      flash_on = 1'b0;
      err_on = 1'b0;
      err_phase = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] v);
      case (idx)
        REG_PULSE_ON:    on_ms = v;
        REG_PULSE_GAP:   gap_ms = v;
        REG_CYCLE_PAUSE: pause_ms = v;
        REG_FLASH_PHASE: flash_ms = v;
        REG_ERROR_PHASE: err_ms = v;
        default: ;
      endcase
    endfunction

    function logic [15:0] sat_bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function void advance_blink();
      logic [15:0] limit;
      blink_cnt = sat_bump(blink_cnt);
      case (phase)
        PH_ON:   limit = on_ms;
        PH_OFF:  limit = gap_ms;
        default: limit = pause_ms;
      endcase
      if (blink_cnt < limit) return;
      blink_cnt = '0;
      case (phase)
        PH_ON: begin
          status = 1'b0;
          pulses_done = pulses_done + 2'd1;
          phase = PH_OFF;
        end
        PH_OFF: begin
          if (pulses_done < pulses_wanted) begin
            status = 1'b1;
            phase = PH_ON;
          end else begin
            phase = PH_PAUSE;
          end
        end
        default: begin
          pulses_done = '0;
          status = 1'b1;
          phase = PH_ON;
        end
      endcase
    endfunction

    function void advance_flash();
      overlay_cnt = sat_bump(overlay_cnt);
      if (overlay_cnt < flash_ms) return;
      overlay_cnt = '0;
      flash_step = flash_step + 4'd1;
      if (flash_step >= FLASH_STEPS) begin
        flash_step = '0;
        flash_on = 1'b0;
        status = 1'b0;
      end
    endfunction

    function void note_input(kind_e k, logic [1:0] m);
      logic [1:0]  sel;
      led_levels_t want;
      if (err_on) begin
        if (k == KIND_TICK) begin
          overlay_cnt = sat_bump(overlay_cnt);
          if (overlay_cnt >= err_ms) begin
            overlay_cnt = '0;
            err_phase = ~err_phase;
          end
        end
      end else if (k == KIND_ERROR) begin
        err_on = 1'b1;
        err_phase = 1'b0;
        overlay_cnt = '0;
        flash_on = 1'b0;
        flash_step = '0;
      end else if (k == KIND_TICK) begin
        advance_blink();
        if (flash_on) advance_flash();
      end else if (!flash_on) begin
        if (k == KIND_MODE) begin
          sel = (m >= MODE_TOTAL) ? 2'd0 : m;
          active_mode = sel;
          pulses_wanted = sel + 2'd1;
          pulses_done = '0;
          phase = PH_ON;
          blink_cnt = '0;
          status = 1'b1;
        end else begin
          flash_on = 1'b1;
          flash_step = '0;
          overlay_cnt = '0;
        end
      end

      if (err_on) begin
        want.status = ~err_phase;
        want.mode_one = ~err_phase;
        want.mode_two = err_phase;
        want.mode_three = err_phase;
      end else if (flash_on) begin
        want.status = ~flash_step[0];
        want.mode_one = ~flash_step[0];
        want.mode_two = ~flash_step[0];
        want.mode_three = ~flash_step[0];
      end else begin
        want.status = status;
        want.mode_one = (active_mode == 2'd0);
        want.mode_two = (active_mode == 2'd1);
        want.mode_three = (active_mode == 2'd2);
      end
      levels_q.push_back(want);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at item %0d: %s", results_seen, msg);
    endtask

    task compare_led(string name, logic got, logic want);
      if (got !== want) report($sformatf("%s got %b expected %b", name, got, want));
    endtask

    task check_result(led_levels_t got);
      led_levels_t want;
      if (levels_q.size() == 0) begin
        report("item returned with nothing pending");
      end else begin
        want = levels_q.pop_front();
        compare_led("status_led", got.status, want.status);
        compare_led("mode_one_led", got.mode_one, want.mode_one);
        compare_led("mode_two_led", got.mode_two, want.mode_two);
        compare_led("mode_three_led", got.mode_three, want.mode_three);
      end
      results_seen++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [1:0]  mode_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        status_led_o;
  logic        mode_one_led_o;
  logic        mode_two_led_o;
  logic        mode_three_led_o;

  led_scoreboard sb;
  bit            hold_req;

  mode_blink_code_led_sequencer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .mode_i          (mode_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_led_o    (status_led_o),
    .mode_one_led_o  (mode_one_led_o),
    .mode_two_led_o  (mode_two_led_o),
    .mode_three_led_o(mode_three_led_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result side
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({status_led_o, mode_one_led_o, mode_two_led_o, mode_three_led_o});
    end
  end

  initial begin
    int unsigned seg_len;
    int unsigned seg_kind;
    out_stall_i = 1'b0;
    forever begin
      seg_len = $urandom_range(10, 60);
      seg_kind = $urandom_range(0, 2);
      repeat (seg_len) begin
        if (hold_req) begin
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_req = 1'b0;
        end
        case (seg_kind)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input kind_e k, input logic [1:0] m);
    in_valid_i <= 1'b1;
    kind_i <= k;
    mode_i <= m;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(k, m);
  endtask

  task automatic idle_cycles(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_one(input reg_idx_e idx, input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic load_regs(input logic [15:0] on_v, gap_v, pause_v, flash_v, err_v);
    write_one(REG_PULSE_ON, on_v);
    write_one(REG_PULSE_GAP, gap_v);
    write_one(REG_CYCLE_PAUSE, pause_v);
    write_one(REG_FLASH_PHASE, flash_v);
    write_one(REG_ERROR_PHASE, err_v);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 16'($urandom_range(1, 65535));
    return 16'($urandom_range(1, 6));
  endfunction

  function automatic kind_e pick_kind(input bit allow_error);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (allow_error && r < 10) return KIND_ERROR;
    if (r < 78) return KIND_TICK;
    if (r < 90) return KIND_MODE;
    return KIND_SAVE;
  endfunction

  task automatic run_random(input int unsigned n, input bit allow_error);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        send_item(pick_kind(allow_error), 2'($urandom_range(0, 3)));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) idle_cycles(gap);
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PULSE_ON;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_TICK;
    mode_i = '0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, out of range mode, save confirm and requests ignored mid flash
    send_item(KIND_TICK, 2'd3);
    send_item(KIND_MODE, 2'd3);
    send_item(KIND_TICK, 2'd0);
    send_item(KIND_SAVE, 2'd0);
    send_item(KIND_MODE, 2'd2);
    send_item(KIND_SAVE, 2'd1);
    send_item(KIND_TICK, 2'd2);
    drain();

    // shortest periods: full three pulse code, then a whole flash
    load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_item(KIND_MODE, 2'd2);
    repeat (7) send_item(KIND_TICK, 2'd1);
    send_item(KIND_SAVE, 2'd3);
    send_item(KIND_MODE, 2'd1);
    repeat (10) send_item(KIND_TICK, 2'd0);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 0) load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else if (p == 1) load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      else load_regs(pick_period(), pick_period(), pick_period(), pick_period(),
                     pick_period());
      if (p == 2) hold_req = 1'b1;
      if (p == 3) begin
        run_random(50, 1'b0);
        drain();
        run_random(50, 1'b0);
      end else begin
        run_random(100, 1'b0);
      end
      drain();
    end

    // error latch, cancelling a running flash, then everything else ignored
    load_regs(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
              16'($urandom_range(1, 4)), 16'($urandom_range(2, 4)),
              16'($urandom_range(1, 4)));
    send_item(KIND_SAVE, 2'd0);
    send_item(KIND_TICK, 2'd1);
    send_item(KIND_TICK, 2'd2);
    send_item(KIND_ERROR, 2'd3);
    repeat (4) send_item(KIND_TICK, 2'd0);
    send_item(KIND_MODE, 2'd1);
    send_item(KIND_SAVE, 2'd2);
    send_item(KIND_ERROR, 2'd0);
    run_random(100, 1'b1);
    drain();
    load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    run_random(40, 1'b1);
    drain();

    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.levels_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/mbcl_pkg.sv
src/mbcl_blink.sv
src/mbcl_overlay.sv
src/mode_blink_code_led_sequencer_unit.sv
dv/tb.sv
